// File: hw/rtl/rotation_matrix_to_quaternion_macros.svh
// Assertion macros used by the checker file.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Same-cycle implication, skipped while dis is true.
`define RMQ_ASSERT_IMPLY(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("rmq assertion failed");

// Next-cycle implication, skipped while dis is true.
`define RMQ_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("rmq assertion failed");

`endif

// File: hw/rtl/rmq_pkg.sv
// Shared types and constants of the matrix-to-quaternion block.
`default_nettype none
package rmq_pkg;
    // Component picked as the largest one.
    typedef enum logic [1:0] {
        COMP_W = 2'd0,
        COMP_X = 2'd1,
        COMP_Y = 2'd2,
        COMP_Z = 2'd3
    } t_comp;

    localparam int SEL_BITS = 2;
    localparam int LANES    = 3;
endpackage
`default_nettype wire

// File: hw/rtl/rmq_mat_if.sv
// Matrix channel: valid, ready and nine matrix elements.
`default_nettype none
interface rmq_mat_if #(parameter int DATA_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] r11, r12, r13;
    logic signed [DATA_WIDTH-1:0] r21, r22, r23;
    logic signed [DATA_WIDTH-1:0] r31, r32, r33;

    modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                    input ready);
    modport sink   (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                    output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rmq_quat_if.sv
// Quaternion channel: valid, ready and four components.
`default_nettype none
interface rmq_quat_if #(parameter int DATA_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quat_w, quat_x, quat_y, quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rmq_fifo.sv
// Short register queue between front and back.
`default_nettype none
module rmq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_ready
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] r_mem;
    logic [PTR_W-1:0]            r_wr, r_rd;
    logic [CNT_W-1:0]            r_cnt;
    logic                        push, pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/rmq_front.sv
// Front end: accept a matrix, form candidates, pick the largest, form differences.
`default_nettype none
module rmq_front #(
    parameter  int DATA_WIDTH = 16,
    localparam int PW = rmq_pkg::SEL_BITS + (DATA_WIDTH + 2) + 3 * (DATA_WIDTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rmq_mat_if.sink       i_mat,
    output logic          o_valid,
    output logic [PW-1:0] o_data,
    input  logic          i_ready
);
    import rmq_pkg::*;

    localparam int CW = DATA_WIDTH + 2;
    localparam int DW = DATA_WIDTH + 1;

    logic signed [CW-1:0] e11, e22, e33, c0, c1, c2, c3, best;
    logic signed [DW-1:0] e12, e13, e21, e23, e31, e32, d1, d2, d3;
    t_comp                sel;
    logic                 r_valid;
    logic [PW-1:0]        r_data, n_data;

    assign e11 = CW'(i_mat.r11);
    assign e22 = CW'(i_mat.r22);
    assign e33 = CW'(i_mat.r33);
    assign e12 = DW'(i_mat.r12);
    assign e13 = DW'(i_mat.r13);
    assign e21 = DW'(i_mat.r21);
    assign e23 = DW'(i_mat.r23);
    assign e31 = DW'(i_mat.r31);
    assign e32 = DW'(i_mat.r32);

    assign c0 = e11 + e22 + e33;
    assign c1 = e11 - e22 - e33;
    assign c2 = e22 - e11 - e33;
    assign c3 = e33 - e11 - e22;

    always_comb begin
        // first of equals wins: only a strictly larger value takes over
        sel  = COMP_W;
        best = c0;
        if (c1 > best) begin
            sel  = COMP_X;
            best = c1;
        end
        if (c2 > best) begin
            sel  = COMP_Y;
            best = c2;
        end
        if (c3 > best) begin
            sel  = COMP_Z;
            best = c3;
        end
        unique case (sel)
            COMP_W: begin
                d1 = e23 - e32; d2 = e31 - e13; d3 = e12 - e21;
            end
            COMP_X: begin
                d1 = e23 - e32; d2 = e12 + e21; d3 = e31 + e13;
            end
            COMP_Y: begin
                d1 = e31 - e13; d2 = e12 + e21; d3 = e23 + e32;
            end
            COMP_Z: begin
                d1 = e12 - e21; d2 = e31 + e13; d3 = e23 + e32;
            end
            default: begin
                d1 = '0; d2 = '0; d3 = '0;
            end
        endcase
        n_data = {sel, best, d1, d2, d3};
    end

    assign i_mat.ready = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_data      = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_mat.ready) begin
            r_valid <= i_mat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mat.ready && i_mat.valid) begin
            r_data <= n_data;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rmq_sqrt #(
    parameter int SW = 16,
    parameter int PW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*SW-1:0] i_x,
    input  logic [PW-1:0]   i_pay,
    output logic            o_valid,
    output logic [SW-1:0]   o_root,
    output logic [PW-1:0]   o_pay
);
    logic [SW-1:0]            v_q;
    logic [SW-1:0][2*SW-1:0]  x_q, res_q;
    logic [SW-1:0][PW-1:0]    pay_q;

    for (genvar s = 0; s < SW; s++) begin : g_stage
        logic            v_in, r_v;
        logic [2*SW-1:0] x_in, res_in, bitc, trial, n_x, n_res, r_x, r_res;
        logic [PW-1:0]   pay_in, r_pay;

        if (s == 0) begin : g_first
            assign v_in   = i_valid;
            assign x_in   = i_x;
            assign res_in = '0;
            assign pay_in = i_pay;
        end else begin : g_next
            assign v_in   = v_q[s-1];
            assign x_in   = x_q[s-1];
            assign res_in = res_q[s-1];
            assign pay_in = pay_q[s-1];
        end

        assign bitc = (2*SW)'(1) << (2 * (SW - 1 - s));

        always_comb begin
            trial = res_in + bitc;
            if (x_in >= trial) begin
                n_x   = x_in - trial;
                n_res = (res_in >> 1) + bitc;
            end else begin
                n_x   = x_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x   <= n_x;
                r_res <= n_res;
                r_pay <= pay_in;
            end
        end

        assign v_q[s]   = r_v;
        assign x_q[s]   = r_x;
        assign res_q[s] = r_res;
        assign pay_q[s] = r_pay;
    end

    assign o_valid = v_q[SW-1];
    assign o_root  = res_q[SW-1][SW-1:0];
    assign o_pay   = pay_q[SW-1];
endmodule
`default_nettype wire

// File: hw/rtl/rmq_div.sv
// Pipelined restoring divider, three numerators over one divisor.
`default_nettype none
module rmq_div #(
    parameter int CW = 40,
    parameter int QW = 16,
    parameter int PW = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [rmq_pkg::LANES-1:0][CW-1:0]   i_num,
    input  logic [CW-1:0]                       i_den,
    input  logic [PW-1:0]                       i_pay,
    output logic                                o_valid,
    output logic [rmq_pkg::LANES-1:0][QW-1:0]   o_quo,
    output logic [rmq_pkg::LANES-1:0]           o_ovf,
    output logic [PW-1:0]                       o_pay
);
    import rmq_pkg::*;

    localparam int NS = QW + 1;

    logic [NS-1:0]                        v_q;
    logic [NS-1:0][LANES-1:0][CW-1:0]     rem_q;
    logic [NS-1:0][LANES-1:0][QW-1:0]     quo_q;
    logic [NS-1:0][LANES-1:0]             ovf_q;
    logic [NS-1:0][CW-1:0]                den_q;
    logic [NS-1:0][PW-1:0]                pay_q;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic                     r_v;
        logic [LANES-1:0][CW-1:0] n_rem, r_rem;
        logic [LANES-1:0][QW-1:0] n_quo, r_quo;
        logic [LANES-1:0]         n_ovf, r_ovf;
        logic [CW-1:0]            n_den, r_den;
        logic [PW-1:0]            n_pay, r_pay;
        logic                     n_v;

        if (s == 0) begin : g_first
            // flag quotients that do not fit in QW bits
            always_comb begin
                n_v   = i_valid;
                n_den = i_den;
                n_pay = i_pay;
                for (int l = 0; l < LANES; l++) begin
                    n_rem[l] = i_num[l];
                    n_quo[l] = '0;
                    n_ovf[l] = (i_num[l] >= (i_den << QW));
                end
            end
        end else begin : g_next
            logic [CW-1:0] sub;
            assign sub = den_q[s-1] << (QW - s);
            always_comb begin
                n_v   = v_q[s-1];
                n_den = den_q[s-1];
                n_pay = pay_q[s-1];
                n_ovf = ovf_q[s-1];
                for (int l = 0; l < LANES; l++) begin
                    n_quo[l] = quo_q[s-1][l];
                    if (rem_q[s-1][l] >= sub) begin
                        n_rem[l]          = rem_q[s-1][l] - sub;
                        n_quo[l][QW - s]  = 1'b1;
                    end else begin
                        n_rem[l] = rem_q[s-1][l];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= n_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_ovf <= n_ovf;
                r_den <= n_den;
                r_pay <= n_pay;
            end
        end

        assign v_q[s]   = r_v;
        assign rem_q[s] = r_rem;
        assign quo_q[s] = r_quo;
        assign ovf_q[s] = r_ovf;
        assign den_q[s] = r_den;
        assign pay_q[s] = r_pay;
    end

    assign o_valid = v_q[NS-1];
    assign o_quo   = quo_q[NS-1];
    assign o_ovf   = ovf_q[NS-1];
    assign o_pay   = pay_q[NS-1];
endmodule
`default_nettype wire

// File: hw/rtl/rmq_back.sv
// Back end: square root, scaling divides, rounding, saturation and output register.
`default_nettype none
module rmq_back #(
    parameter  int DATA_WIDTH = 16,
    parameter  int FRAC_BITS  = 14,
    localparam int PW = rmq_pkg::SEL_BITS + (DATA_WIDTH + 2) + 3 * (DATA_WIDTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [PW-1:0] i_data,
    output logic          o_ready,
    rmq_quat_if.source    o_quat
);
    import rmq_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int CCW  = W + 2;
    localparam int DW   = W + 1;
    localparam int TW   = ((W + 2 > FRAC_BITS + 2) ? W + 2 : FRAC_BITS + 2) + 1;
    localparam int XW   = TW - 1 + FRAC_BITS;
    localparam int SW   = (XW + 1) / 2;
    localparam int SP   = SEL_BITS + 3 * DW;
    localparam int DP   = SEL_BITS + LANES + SW;
    localparam int NA   = W + FRAC_BITS + 2;
    localparam int NB   = SW + W + 3;
    localparam int CW   = ((NA > NB) ? NA : NB) + 1;
    localparam int BW   = (SW > W) ? SW : W;

    logic                 en;
    logic [SEL_BITS-1:0]  in_sel;
    logic signed [CCW-1:0] in_best;
    logic signed [DW-1:0] in_d1, in_d2, in_d3;
    logic signed [TW-1:0] t_val;
    logic [2*SW-1:0]      x_val;

    logic                 sq_v;
    logic [SW-1:0]        sq_root;
    logic [SP-1:0]        sq_pay;
    logic [SW:0]          root_inc;

    logic                 r_b_v;
    logic [SEL_BITS-1:0]  r_b_sel;
    logic [SW-1:0]        r_b_big;
    logic [LANES-1:0]     r_b_neg;
    logic [LANES-1:0][DW-1:0] r_b_mag;
    logic [LANES-1:0][DW-1:0] sq_d;

    logic [LANES-1:0][CW-1:0] dv_num;
    logic [CW-1:0]            dv_den;
    logic                     dv_v;
    logic [LANES-1:0][W-1:0]  dv_quo;
    logic [LANES-1:0]         dv_ovf;
    logic [DP-1:0]            dv_pay;

    t_comp                    o_sel;
    logic [LANES-1:0]         o_neg;
    logic [SW-1:0]            o_big;
    logic [W-1:0]             big_word;
    logic [LANES-1:0][W-1:0]  oth;
    logic [W-1:0]             hi_w, lo_w;

    logic                 r_out_v;
    logic [W-1:0]         r_w, r_x, r_y, r_z, n_w, n_x, n_y, n_z;

    assign en      = !r_out_v || o_quat.ready;
    assign o_ready = en;

    assign {in_sel, in_best, in_d1, in_d2, in_d3} = i_data;
    assign t_val = TW'(in_best) + (TW'(1) << FRAC_BITS);
    assign x_val = (t_val > 0) ? ((2*SW)'(t_val[TW-2:0]) << FRAC_BITS) : '0;

    rmq_sqrt #(.SW(SW), .PW(SP)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_x     (x_val),
        .i_pay   ({in_sel, in_d1, in_d2, in_d3}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_pay   (sq_pay)
    );

    assign root_inc = (SW+1)'(sq_root) + 1'b1;
    assign sq_d[0]  = sq_pay[3*DW-1:2*DW];
    assign sq_d[1]  = sq_pay[2*DW-1:DW];
    assign sq_d[2]  = sq_pay[DW-1:0];

    // round the root, split differences into sign and magnitude
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_sel <= sq_pay[SP-1:3*DW];
            r_b_big <= root_inc[SW:1];
            for (int l = 0; l < LANES; l++) begin
                r_b_neg[l] <= sq_d[l][DW-1];
                r_b_mag[l] <= sq_d[l][DW-1] ? (~sq_d[l] + 1'b1) : sq_d[l];
            end
        end
    end

    // round(|d| * 2^F / (4*big)) = floor((|d| * 2^(F+1) + 4*big) / (8*big))
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            dv_num[l] = (CW'(r_b_mag[l]) << (FRAC_BITS + 1)) + (CW'(r_b_big) << 2);
        end
        dv_den = CW'(r_b_big) << 3;
    end

    rmq_div #(.CW(CW), .QW(W), .PW(DP)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_v),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .i_pay   ({r_b_sel, r_b_neg, r_b_big}),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_ovf   (dv_ovf),
        .o_pay   (dv_pay)
    );

    assign hi_w = {1'b0, {(W-1){1'b1}}};
    assign lo_w = {1'b1, {(W-1){1'b0}}};

    always_comb begin
        o_sel = t_comp'(dv_pay[DP-1:DP-SEL_BITS]);
        o_neg = dv_pay[SW+LANES-1:SW];
        o_big = dv_pay[SW-1:0];
        big_word = (BW'(o_big) > BW'(hi_w)) ? hi_w : W'(o_big);
        for (int l = 0; l < LANES; l++) begin
            if (o_big == '0) begin
                oth[l] = '0;
            end else if (!o_neg[l]) begin
                oth[l] = (dv_ovf[l] || (dv_quo[l] > hi_w)) ? hi_w : dv_quo[l];
            end else begin
                oth[l] = (dv_ovf[l] || (dv_quo[l] > lo_w)) ? lo_w : (~dv_quo[l] + 1'b1);
            end
        end
        unique case (o_sel)
            COMP_W: begin
                n_w = big_word; n_x = oth[0]; n_y = oth[1]; n_z = oth[2];
            end
            COMP_X: begin
                n_w = oth[0]; n_x = big_word; n_y = oth[1]; n_z = oth[2];
            end
            COMP_Y: begin
                n_w = oth[0]; n_x = oth[1]; n_y = big_word; n_z = oth[2];
            end
            COMP_Z: begin
                n_w = oth[0]; n_x = oth[1]; n_y = oth[2]; n_z = big_word;
            end
            default: begin
                n_w = '0; n_x = '0; n_y = '0; n_z = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w <= n_w;
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_quat.valid  = r_out_v;
    assign o_quat.quat_w = r_w;
    assign o_quat.quat_x = r_x;
    assign o_quat.quat_y = r_y;
    assign o_quat.quat_z = r_z;
endmodule
`default_nettype wire

// File: hw/rtl/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to quaternion converter (largest-component method).
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  i_mat    | in  | valid / ready | r11 .. r33, signed, DATA_WIDTH bits each
//  o_quat   | out | valid / ready | quat_w .. quat_z, signed, DATA_WIDTH bits
//
//  One transaction per cycle sustained while o_quat.ready is high; results pass
//  the one-bit-per-stage root pipeline, whose root width SW is 16 at the
//  defaults, and the one-bit-per-stage divide pipeline.
//  Reset is synchronous, active low, and clears every valid flag at once.
//  A stalled output freezes the back pipeline; the two-entry queue and the
//  front register keep taking matrices until they fill.
`default_nettype none
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmq_mat_if.sink    i_mat,
    rmq_quat_if.source o_quat
);
    import rmq_pkg::*;

    // front payload: selected component, its candidate, three differences
    localparam int PW = SEL_BITS + (DATA_WIDTH + 2) + 3 * (DATA_WIDTH + 1);

    logic          fr_valid, fr_ready;
    logic [PW-1:0] fr_data;
    logic          q_valid, q_ready;
    logic [PW-1:0] q_data;

    // classify: candidates and the winner, registered once
    rmq_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (i_mat),
        .o_valid (fr_valid),
        .o_data  (fr_data),
        .i_ready (fr_ready)
    );

    // decouple: lets the front run on while the back holds for o_quat.ready
    rmq_fifo #(.WIDTH(PW), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_data  (fr_data),
        .o_ready (fr_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_ready (q_ready)
    );

    // execute: root, three scaled quotients, saturation, output register
    rmq_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_data  (q_data),
        .o_ready (q_ready),
        .o_quat  (o_quat)
    );
endmodule
`default_nettype wire

// File: hw/rtl/rmq_checker.sv
// Port-level checker for the converter and its bind.
`default_nettype none
`include "rotation_matrix_to_quaternion_macros.svh"
module rmq_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [DATA_WIDTH-1:0] i_w,
    input logic [DATA_WIDTH-1:0] i_x,
    input logic [DATA_WIDTH-1:0] i_y,
    input logic [DATA_WIDTH-1:0] i_z
);
    logic [7:0] r_cnt;
    logic       in_acc, out_acc;
    logic       all_neg;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;
    assign all_neg = i_w[DATA_WIDTH-1] && i_x[DATA_WIDTH-1]
                  && i_y[DATA_WIDTH-1] && i_z[DATA_WIDTH-1];

    // track transactions in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    `RMQ_ASSERT_NEXT(a_reset_idle, i_clk, 1'b0, !i_rst_n, !i_out_valid)
    `RMQ_ASSERT_NEXT(a_hold, i_clk, !i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_w) && $stable(i_x) && $stable(i_y) && $stable(i_z))
    `RMQ_ASSERT_IMPLY(a_no_extra, i_clk, !i_rst_n, out_acc, r_cnt != 8'd0)
    `RMQ_ASSERT_IMPLY(a_one_nonneg, i_clk, !i_rst_n, i_out_valid, !all_neg)
endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_mat.valid),
    .i_in_ready  (i_mat.ready),
    .i_out_valid (o_quat.valid),
    .i_out_ready (o_quat.ready),
    .i_w         (o_quat.quat_w),
    .i_x         (o_quat.quat_x),
    .i_y         (o_quat.quat_y),
    .i_z         (o_quat.quat_z)
);
`default_nettype wire

// File: tb/rmq_tb_pkg.sv
// Testbench package: matrix and quaternion records.
`timescale 1ns / 1ps
package rmq_tb_pkg;
    typedef struct packed {
        logic signed [15:0] r11, r12, r13, r21, r22, r23, r31, r32, r33;
    } t_matrix;

    typedef struct packed {
        logic signed [15:0] w, x, y, z;
    } t_quat;
endpackage

// File: tb/rotation_matrix_to_quaternion_tb.sv
// Testbench: streams matrices through the converter and checks each quaternion.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_tb;
    import rmq_pkg::*;
    import rmq_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int N_RANDOM       = 1525;
    localparam logic signed [15:0] ONE  = 16'sd16384;
    localparam logic signed [15:0] HALF = 16'sd8192;
    localparam logic signed [15:0] PMAX = 16'sh7fff;
    localparam logic signed [15:0] NMAX = 16'sh8000;

    logic i_clk;
    logic i_rst_n;
    rmq_mat_if  #(.DATA_WIDTH(16)) mat_ch ();
    rmq_quat_if #(.DATA_WIDTH(16)) quat_ch ();

    rotation_matrix_to_quaternion #(.DATA_WIDTH(16), .FRAC_BITS(14)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_mat  (mat_ch.sink),
        .o_quat (quat_ch.source)
    );

    t_quat pending_quats[$];
    int    n_errors;
    int    idle_cycles;
    int    send_idle_pct;
    int    recv_stall_pct;
    bit    stim_done;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Floor square root by the bit-pair method.
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return PMAX;
        if (v < -32768) return NMAX;
        return v[15:0];
    endfunction

    // round(d * 2^14 / (4 * big)), ties away from zero.
    function automatic logic signed [15:0] off_diag_quot(longint d, longint unsigned big);
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        den = big * 4;
        q = ((mag << 14) * 2 + den) / (den * 2);
        return clamp16((d < 0) ? -longint'(q) : longint'(q));
    endfunction

    // Shepperd's largest-component selection in fixed point.
    function automatic t_quat quat_of_matrix(t_matrix m);
        longint c[4];
        longint m11, m12, m13, m21, m22, m23, m31, m32, m33;
        longint d1, d2, d3, t;
        longint unsigned big;
        logic signed [15:0] o1, o2, o3, bv;
        t_comp sel;
        t_quat q;
        m11 = m.r11; m12 = m.r12; m13 = m.r13;
        m21 = m.r21; m22 = m.r22; m23 = m.r23;
        m31 = m.r31; m32 = m.r32; m33 = m.r33;
        c[0] = m11 + m22 + m33;
        c[1] = m11 - m22 - m33;
        c[2] = m22 - m11 - m33;
        c[3] = m33 - m11 - m22;
        sel = COMP_W;
        for (int i = 1; i < 4; i++)
            if (c[i] > c[sel]) sel = t_comp'(i);
        t = c[sel] + 16384;
        big = (t <= 0) ? 0 : (floor_root(longint'(t) << 14) + 1) >> 1;
        case (sel)
            COMP_W: begin d1 = m23 - m32; d2 = m31 - m13; d3 = m12 - m21; end
            COMP_X: begin d1 = m23 - m32; d2 = m12 + m21; d3 = m31 + m13; end
            COMP_Y: begin d1 = m31 - m13; d2 = m12 + m21; d3 = m23 + m32; end
            default: begin d1 = m12 - m21; d2 = m31 + m13; d3 = m23 + m32; end
        endcase
        o1 = big ? off_diag_quot(d1, big) : '0;
        o2 = big ? off_diag_quot(d2, big) : '0;
        o3 = big ? off_diag_quot(d3, big) : '0;
        bv = clamp16(longint'(big));
        case (sel)
            COMP_W: q = '{w: bv, x: o1, y: o2, z: o3};
            COMP_X: q = '{w: o1, x: bv, y: o2, z: o3};
            COMP_Y: q = '{w: o1, x: o2, y: bv, z: o3};
            default: q = '{w: o1, x: o2, y: o3, z: bv};
        endcase
        return q;
    endfunction

    task automatic report_mismatch(string what, logic signed [15:0] got,
                                   logic signed [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // Receiver: random stalls, compare each quaternion with the oldest expectation.
    always @(posedge i_clk) begin
        t_quat want;
        if (!i_rst_n) begin
            quat_ch.ready <= 1'b0;
        end else begin
            if (quat_ch.valid && quat_ch.ready) begin
                if (pending_quats.size() == 0) begin
                    $display("unexpected quaternion at %0t", $time);
                    n_errors++;
                end else begin
                    want = pending_quats.pop_front();
                    if (quat_ch.quat_w !== want.w) report_mismatch("w", quat_ch.quat_w, want.w);
                    if (quat_ch.quat_x !== want.x) report_mismatch("x", quat_ch.quat_x, want.x);
                    if (quat_ch.quat_y !== want.y) report_mismatch("y", quat_ch.quat_y, want.y);
                    if (quat_ch.quat_z !== want.z) report_mismatch("z", quat_ch.quat_z, want.z);
                end
            end
            quat_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((mat_ch.valid && mat_ch.ready) || (quat_ch.valid && quat_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("** rotation_matrix_to_quaternion: FAILED **");
            $finish;
        end
    end

    // Present one matrix, hold it until accepted; queue its prediction.
    // Valid stays high into the next matrix unless the sender idles.
    task automatic send_matrix(t_matrix m, bit has_want, t_quat want);
        if ($urandom_range(99) < send_idle_pct) begin
            mat_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        mat_ch.valid <= 1'b1;
        {mat_ch.r11, mat_ch.r12, mat_ch.r13, mat_ch.r21, mat_ch.r22,
         mat_ch.r23, mat_ch.r31, mat_ch.r32, mat_ch.r33} <= m;
        do @(posedge i_clk); while (!mat_ch.ready);
        pending_quats.push_back(has_want ? want : quat_of_matrix(m));
    endtask

    function automatic logic signed [15:0] rand_elem(int mode);
        case (mode)
            0: return 16'($urandom());
            1: return $urandom_range(2) == 0 ? NMAX : ($urandom_range(1) ? PMAX : 16'sd0);
            default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
        endcase
    endfunction

    // Rotation-like matrix: pick a dominant diagonal slot, off-diagonals from -ONE to ONE.
    function automatic t_matrix rand_rotation_like();
        t_matrix m;
        int dom;
        m = '0;
        dom = $urandom_range(3);
        m.r11 = (dom == 1 || dom == 0) ? ONE - 16'($urandom_range(6000))
                                       : -ONE + 16'($urandom_range(20000));
        m.r22 = (dom == 2 || dom == 0) ? ONE - 16'($urandom_range(6000))
                                       : -ONE + 16'($urandom_range(20000));
        m.r33 = (dom == 3 || dom == 0) ? ONE - 16'($urandom_range(6000))
                                       : -ONE + 16'($urandom_range(20000));
        m.r12 = $signed(16'($urandom_range(32768))) - 16'sd16384;
        m.r13 = $signed(16'($urandom_range(32768))) - 16'sd16384;
        m.r21 = $signed(16'($urandom_range(32768))) - 16'sd16384;
        m.r23 = $signed(16'($urandom_range(32768))) - 16'sd16384;
        m.r31 = $signed(16'($urandom_range(32768))) - 16'sd16384;
        m.r32 = $signed(16'($urandom_range(32768))) - 16'sd16384;
        return m;
    endfunction

    typedef struct {
        t_matrix m;
        bit      has_want;
        t_quat   want;
    } t_stim_row;

    t_stim_row directed[$];

    task automatic add_row(t_matrix m, bit has_want, t_quat want);
        t_stim_row r;
        r.m = m; r.has_want = has_want; r.want = want;
        directed.push_back(r);
    endtask

    // Drop valid and hold off until every expected quaternion has come.
    task automatic wait_drain();
        mat_ch.valid <= 1'b0;
        while (pending_quats.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_matrix m;
        int phase_idle[4];
        int phase_stall[4];
        n_errors = 0;
        idle_cycles = 0;
        stim_done = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        mat_ch.valid = 1'b0;
        {mat_ch.r11, mat_ch.r12, mat_ch.r13, mat_ch.r21, mat_ch.r22,
         mat_ch.r23, mat_ch.r31, mat_ch.r32, mat_ch.r33} = '0;
        quat_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Identity: w = 1.0, rest zero.
        add_row('{r11: ONE, r22: ONE, r33: ONE, default: 0}, 1,
                '{w: ONE, default: 0});
        // 180 degrees about x, y and z: that component is 1.0.
        add_row('{r11: ONE, r22: -ONE, r33: -ONE, default: 0}, 1,
                '{x: ONE, default: 0});
        add_row('{r11: -ONE, r22: ONE, r33: -ONE, default: 0}, 1,
                '{y: ONE, default: 0});
        add_row('{r11: -ONE, r22: -ONE, r33: ONE, default: 0}, 1,
                '{z: ONE, default: 0});
        // All zero: equal candidates pick w; sqrt(1)/2 = 0.5.
        add_row('0, 1, '{w: HALF, default: 0});
        // Negative diagonals: x, y and z tie and x wins.
        add_row('{r11: NMAX, r22: NMAX, r33: NMAX, default: 0}, 0, '0);
        add_row('{r11: -ONE, r22: -ONE, r33: -ONE, default: 0}, 0, '0);
        // Saturation of the off-diagonal quotients.
        add_row('{r11: ONE, r22: ONE, r33: ONE, r23: PMAX, r32: NMAX,
                  r31: NMAX, r13: PMAX, r12: PMAX, r21: PMAX, default: 0}, 0, '0);
        add_row('{r11: -ONE, r22: -ONE, r33: -16'sd16000, r12: PMAX, r21: PMAX,
                  r13: NMAX, r31: NMAX, r23: PMAX, r32: NMAX, default: 0}, 0, '0);
        // Extremes of every element, and alternating bit patterns.
        add_row('{default: PMAX}, 0, '0);
        add_row('{default: NMAX}, 0, '0);
        add_row('{r11: PMAX, r22: NMAX, r33: NMAX, default: PMAX}, 0, '0);
        add_row('{r11: NMAX, r22: PMAX, r33: NMAX, default: NMAX}, 0, '0);
        add_row('{r11: NMAX, r22: NMAX, r33: PMAX, default: 16'sh5555}, 0, '0);
        add_row('{default: 16'shaaaa}, 0, '0);
        // Ties between x and y, and y and z.
        add_row('{r11: 16'sd8000, r22: 16'sd8000, r33: -ONE, r12: 16'sd300, default: 0},
                0, '0);
        add_row('{r11: -ONE, r22: 16'sd5000, r33: 16'sd5000, r23: -16'sd77, default: 0},
                0, '0);

        foreach (directed[i]) send_matrix(directed[i].m, directed[i].has_want, directed[i].want);
        // Hold off until every expected quaternion has come.
        wait_drain();

        phase_idle  = '{0, 72, 0, 26};
        phase_stall = '{0, 0, 72, 26};
        for (int n = 0; n < N_RANDOM; n++) begin
            send_idle_pct  = phase_idle[(n * 4) / N_RANDOM];
            recv_stall_pct = phase_stall[(n * 4) / N_RANDOM];
            if ($urandom_range(99) < 75) begin
                m = rand_rotation_like();
            end else begin
                int mode;
                mode = $urandom_range(2);
                m = '{rand_elem(mode), rand_elem(mode), rand_elem(mode),
                      rand_elem(mode), rand_elem(mode), rand_elem(mode),
                      rand_elem(mode), rand_elem(mode), rand_elem(mode)};
            end
            send_matrix(m, 0, '0);
            if (n == N_RANDOM / 2) wait_drain();
        end
        stim_done = 1;
        recv_stall_pct = 0;
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending_quats.size() == 0) begin
            $display("** rotation_matrix_to_quaternion: PASSED **");
        end else begin
            $display("** rotation_matrix_to_quaternion: FAILED **");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_mat_if.sv
hw/rtl/rmq_quat_if.sv
hw/rtl/rmq_fifo.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_sqrt.sv
hw/rtl/rmq_div.sv
hw/rtl/rmq_back.sv
hw/rtl/rotation_matrix_to_quaternion.sv
hw/rtl/rmq_checker.sv
tb/rmq_tb_pkg.sv
tb/rotation_matrix_to_quaternion_tb.sv
